@@ rtl/mplg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the memory pressure level governor.
// No dependencies; used by the top level, its port checker and the testbench.
package mplg_pkg;

  localparam int unsigned CfgDataW = 20;
  localparam int unsigned MbW      = 20;
  localparam int unsigned TimerW   = 32;
  localparam int unsigned LevelW   = 2;

  typedef logic [LevelW-1:0] level_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgThrMid      = 3'd0,
    CfgThrLow      = 3'd1,
    CfgThrVeryLow  = 3'd2,
    CfgDwellBase   = 3'd3,
    CfgDwellL2     = 3'd4,
    CfgDwellL3     = 3'd5,
    CfgWarmup      = 3'd6,
    CfgLevelLimit  = 3'd7
  } cfg_idx_e;

  // Register reset values
  localparam logic [19:0] ThrMidRst      = 20'd1150;
  localparam logic [19:0] ThrLowRst      = 20'd1250;
  localparam logic [19:0] ThrVeryLowRst  = 20'd1300;
  localparam logic [19:0] DwellBaseRst   = 20'd60000;
  localparam logic [19:0] DwellL2Rst     = 20'd30000;
  localparam logic [19:0] DwellL3Rst     = 20'd15000;
  localparam logic [15:0] WarmupRst      = 16'd500;
  localparam level_t      LevelLimitRst  = 2'd3;
  localparam level_t      LevelTopRst    = 2'd3;

  typedef struct packed {
    logic [15:0] time_delta_ms;
    logic [39:0] working_set_bytes;
    logic        sample_valid;
  } in_item_t;

  typedef struct packed {
    level_t          level;
    logic            level_changed;
    level_t          target;
    logic [MbW-1:0]  average_mb;
  } out_item_t;

  // Saturating 32-bit add of a 16-bit increment
  function automatic logic [TimerW-1:0] sat_add(input logic [TimerW-1:0] a,
                                                 input logic [15:0] b);
    logic [TimerW:0] s;
    s = {1'b0, a} + {{(TimerW - 15){1'b0}}, b};
    return s[TimerW] ? {TimerW{1'b1}} : s[TimerW-1:0];
  endfunction

endpackage

@@ rtl/memory_pressure_level_governor.sv @@
`timescale 1ns / 1ps
// Memory pressure level governor: sample ring, running average, level control.
// Depends on mplg_pkg for payload types, register codes and reset values.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one tick per
//   transfer: elapsed ms, working set and a sample flag. Every tick gives
//   exactly one result on the output channel (out_valid_o/out_ready_i/
//   out_data_o): current level, change flag, clamped target and ring average.
//   The result of a tick is registered at the edge that accepts it. Throughput
//   is one tick per cycle while the receiver takes each result; the whole state
//   update (ring sum, classification, dwell compare) sits between the accepting
//   edge and the result register.
//   The sample ring is a RING_DEPTH x 20 memory with one write and one
//   registered read per cycle; its read for the next slot is fetched at the
//   edge that moves to that slot. The first sample does not sweep the ring:
//   entries not yet overwritten since then read as that first value.
//   Reset: thresholds, dwell times, warm-up and limit take their defaults,
//   level and target go to three, timers and sum clear, no result is pending.
//   No clearing pass is needed, so ticks are taken from the first cycle.
//   When the receiver stalls, the result is held in the output register and
//   in_ready_o drops until it is taken; a tick is accepted in the same cycle
//   as the pending result is transferred.
//   Configuration writes (cfg_we_i) are applied at once, only while idle.
module memory_pressure_level_governor #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [mplg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  mplg_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mplg_pkg::out_item_t        out_data_o
);

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam int unsigned SumW = mplg_pkg::MbW + IdxW;
  localparam logic [IdxW-1:0] LastPos = IdxW'(RING_DEPTH - 1);

  // Configuration registers
  logic [19:0] thr_mid_q, thr_low_q, thr_verylow_q;
  logic [19:0] dwell_base_q, dwell_l2_q, dwell_l3_q;
  logic [15:0] warmup_ms_q;
  mplg_pkg::level_t level_limit_q;

  // Governor state
  logic                              first_pending_q, first_pending_d;
  logic                              lap_done_q, lap_done_d;
  logic [IdxW-1:0]                   ring_pos_q, ring_pos_d;
  logic [SumW-1:0]                   ring_sum_q, ring_sum_d;
  logic [mplg_pkg::TimerW-1:0]       warmup_q, warmup_d;
  logic [mplg_pkg::TimerW-1:0]       dwell_q, dwell_d;
  mplg_pkg::level_t                  level_q, level_d;
  mplg_pkg::level_t                  target_q, target_d;
  logic [mplg_pkg::MbW-1:0]          first_mb_q;
  logic [mplg_pkg::MbW-1:0]          rd_q;
  logic [mplg_pkg::MbW-1:0]          ring_mem [RING_DEPTH];

  logic                              out_valid_q;
  mplg_pkg::out_item_t               out_data_q, out_data_d;

  logic                              in_xfer;
  logic                              take_first, take_rec;
  logic [mplg_pkg::MbW-1:0]          mb, old_mb, avg_new;
  logic [mplg_pkg::TimerW-1:0]       dwell_acc;
  logic [19:0]                       dwell_lim;
  mplg_pkg::level_t                  cls, cls_clamped;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign mb         = in_data_i.working_set_bytes[39:20];
  assign take_first = in_data_i.sample_valid && first_pending_q;
  assign take_rec   = in_data_i.sample_valid && !first_pending_q
                      && (warmup_q > {16'b0, warmup_ms_q});
  // Slots not overwritten since the first sample still hold that sample
  assign old_mb     = lap_done_q ? rd_q : first_mb_q;

  always_comb begin
    ring_sum_d      = ring_sum_q;
    ring_pos_d      = ring_pos_q;
    lap_done_d      = lap_done_q;
    first_pending_d = first_pending_q;
    warmup_d        = warmup_q;
    if (take_first) begin
      ring_sum_d      = {mb, {IdxW{1'b0}}};
      ring_pos_d      = '0;
      lap_done_d      = 1'b0;
      first_pending_d = 1'b0;
      warmup_d        = '0;
    end else if (in_data_i.sample_valid) begin
      if (take_rec) begin
        ring_sum_d = ring_sum_q - SumW'(old_mb) + SumW'(mb);
        ring_pos_d = ring_pos_q + 1'b1;
        if (ring_pos_q == LastPos) begin
          lap_done_d = 1'b1;
        end
      end
      warmup_d = mplg_pkg::sat_add(warmup_q, in_data_i.time_delta_ms);
    end
  end

  assign avg_new = ring_sum_d[SumW-1 -: mplg_pkg::MbW];

  always_comb begin
    if (avg_new > thr_verylow_q) begin
      cls = 2'd0;
    end else if (avg_new > thr_low_q) begin
      cls = 2'd1;
    end else if (avg_new > thr_mid_q) begin
      cls = 2'd2;
    end else begin
      cls = 2'd3;
    end
    cls_clamped = (cls > level_limit_q) ? level_limit_q : cls;
    target_d    = (take_first || take_rec) ? cls_clamped : target_q;
  end

  always_comb begin
    case (level_q)
      2'd0:    dwell_lim = dwell_base_q;
      2'd1:    dwell_lim = dwell_l2_q;
      default: dwell_lim = dwell_l3_q;
    endcase
    dwell_acc = mplg_pkg::sat_add(dwell_q, in_data_i.time_delta_ms);
    level_d   = level_q;
    dwell_d   = dwell_acc;
    if (target_d < level_q) begin
      // drop straight to the target
      level_d = target_d;
      dwell_d = '0;
    end else if (target_d > level_q && dwell_acc > {12'b0, dwell_lim}) begin
      level_d = level_q + 1'b1;
      dwell_d = '0;
    end
  end

  always_comb begin
    out_data_d.level         = level_d;
    out_data_d.level_changed = (level_d != level_q);
    out_data_d.target        = target_d;
    out_data_d.average_mb    = avg_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_mid_q       <= mplg_pkg::ThrMidRst;
      thr_low_q       <= mplg_pkg::ThrLowRst;
      thr_verylow_q   <= mplg_pkg::ThrVeryLowRst;
      dwell_base_q    <= mplg_pkg::DwellBaseRst;
      dwell_l2_q      <= mplg_pkg::DwellL2Rst;
      dwell_l3_q      <= mplg_pkg::DwellL3Rst;
      warmup_ms_q     <= mplg_pkg::WarmupRst;
      level_limit_q   <= mplg_pkg::LevelLimitRst;
      first_pending_q <= 1'b1;
      lap_done_q      <= 1'b0;
      ring_pos_q      <= '0;
      ring_sum_q      <= '0;
      warmup_q        <= '0;
      dwell_q         <= '0;
      level_q         <= mplg_pkg::LevelTopRst;
      target_q        <= mplg_pkg::LevelTopRst;
      out_valid_q     <= 1'b0;
    end else begin
      if (in_xfer) begin
        first_pending_q <= first_pending_d;
        lap_done_q      <= lap_done_d;
        ring_pos_q      <= ring_pos_d;
        ring_sum_q      <= ring_sum_d;
        warmup_q        <= warmup_d;
        dwell_q         <= dwell_d;
        level_q         <= level_d;
        target_q        <= target_d;
      end else if (cfg_we_i) begin
        unique case (mplg_pkg::cfg_idx_e'(cfg_idx_i))
          mplg_pkg::CfgThrMid:     thr_mid_q     <= cfg_data_i;
          mplg_pkg::CfgThrLow:     thr_low_q     <= cfg_data_i;
          mplg_pkg::CfgThrVeryLow: thr_verylow_q <= cfg_data_i;
          mplg_pkg::CfgDwellBase:  dwell_base_q  <= cfg_data_i;
          mplg_pkg::CfgDwellL2:    dwell_l2_q    <= cfg_data_i;
          mplg_pkg::CfgDwellL3:    dwell_l3_q    <= cfg_data_i;
          mplg_pkg::CfgWarmup:     warmup_ms_q   <= cfg_data_i[15:0];
          mplg_pkg::CfgLevelLimit: begin
            level_limit_q <= cfg_data_i[1:0];
            // clamp the held target to the new limit
            if (target_q > cfg_data_i[1:0]) begin
              target_q <= cfg_data_i[1:0];
            end
          end
          default: ;
        endcase
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Ring memory: one write, one registered read of the next slot
  always_ff @(posedge clk_i) begin
    if (in_xfer && take_rec) begin
      ring_mem[ring_pos_q] <= mb;
    end
    rd_q <= ring_mem[in_xfer ? ring_pos_d : ring_pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && take_first) begin
      first_mb_q <= mb;
    end
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/mplg_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the memory pressure level governor, with its bind.
// Depends on mplg_pkg for the payload struct types.
module mplg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mplg_pkg::out_item_t out_data_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Each accepted tick gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted tick");

  // Nothing pending means a tick can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // Level never sits above the target after a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.level <= out_data_o.target)
    else $error("level above target");

endmodule

bind memory_pressure_level_governor mplg_checker u_mplg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ tb/memory_pressure_level_governor_tb.sv @@
`timescale 1ns / 1ps
// Testbench for memory_pressure_level_governor: directed and random ticks, random stalls.
// Depends on mplg_pkg and the governor RTL; predicts each level result and checks it.

class governor_scoreboard;
  localparam int Depth = 16;

  logic [19:0]       thr_mid, thr_low, thr_vlow;
  logic [19:0]       dwell_base, dwell_l2, dwell_l3;
  logic [15:0]       warmup;
  mplg_pkg::level_t  limit;

  bit                first_pending;
  logic [19:0]       ring [Depth];
  logic [3:0]        slot;
  logic [23:0]       sum;
  logic [31:0]       warm_ms;
  logic [31:0]       dwell_ms;
  mplg_pkg::level_t  cur_level;
  mplg_pkg::level_t  tgt_level;

  mplg_pkg::out_item_t levels_due [$];
  int                errors;

  function new();
    thr_mid       = mplg_pkg::ThrMidRst;
    thr_low       = mplg_pkg::ThrLowRst;
    thr_vlow      = mplg_pkg::ThrVeryLowRst;
    dwell_base    = mplg_pkg::DwellBaseRst;
    dwell_l2      = mplg_pkg::DwellL2Rst;
    dwell_l3      = mplg_pkg::DwellL3Rst;
    warmup        = mplg_pkg::WarmupRst;
    limit         = mplg_pkg::LevelLimitRst;
    first_pending = 1'b1;
    slot          = '0;
    sum           = '0;
    warm_ms       = '0;
    dwell_ms      = '0;
    cur_level     = mplg_pkg::LevelTopRst;
    tgt_level     = mplg_pkg::LevelTopRst;
    errors        = 0;
  endfunction

  function void write_reg(mplg_pkg::cfg_idx_e idx, logic [19:0] v);
    case (idx)
      mplg_pkg::CfgThrMid:     thr_mid    = v;
      mplg_pkg::CfgThrLow:     thr_low    = v;
      mplg_pkg::CfgThrVeryLow: thr_vlow   = v;
      mplg_pkg::CfgDwellBase:  dwell_base = v;
      mplg_pkg::CfgDwellL2:    dwell_l2   = v;
      mplg_pkg::CfgDwellL3:    dwell_l3   = v;
      mplg_pkg::CfgWarmup:     warmup     = v[15:0];
      mplg_pkg::CfgLevelLimit: begin
        limit = v[1:0];
        // a lower limit pulls the held target down at once
        if (tgt_level > limit) tgt_level = limit;
      end
      default: ;
    endcase
  endfunction

  function mplg_pkg::level_t classify_avg(logic [19:0] avg);
    mplg_pkg::level_t t;
    if (avg > thr_vlow)     t = 2'd0;
    else if (avg > thr_low) t = 2'd1;
    else if (avg > thr_mid) t = 2'd2;
    else                    t = 2'd3;
    if (t > limit) t = limit;
    return t;
  endfunction

  function logic [31:0] bump(logic [31:0] acc, logic [15:0] step);
    logic [32:0] s;
    s = {1'b0, acc} + {17'd0, step};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function void note_tick(mplg_pkg::in_item_t t);
    logic [19:0]         mb;
    logic [19:0]         dw;
    mplg_pkg::level_t    prev;
    mplg_pkg::out_item_t r;
    mb   = t.working_set_bytes[39:20];
    prev = cur_level;
    if (t.sample_valid) begin
      if (first_pending) begin
        // first sample fills the whole ring; warm-up timer restarts from zero this tick
        first_pending = 1'b0;
        slot          = '0;
        warm_ms       = '0;
        foreach (ring[i]) ring[i] = mb;
        sum       = {mb, 4'b0000};
        tgt_level = classify_avg(mb);
      end else begin
        if (warm_ms > {16'd0, warmup}) begin
          sum        = sum - ring[slot] + mb;
          ring[slot] = mb;
          slot       = slot + 4'd1;
          tgt_level  = classify_avg(sum[23:4]);
        end
        warm_ms = bump(warm_ms, t.time_delta_ms);
      end
    end
    dwell_ms = bump(dwell_ms, t.time_delta_ms);
    if (tgt_level < cur_level) begin
      dwell_ms  = '0;
      cur_level = tgt_level;
    end else if (tgt_level > cur_level) begin
      if (cur_level == 2'd0)      dw = dwell_base;
      else if (cur_level == 2'd1) dw = dwell_l2;
      else                        dw = dwell_l3;
      if (dwell_ms > {12'd0, dw}) begin
        dwell_ms  = '0;
        cur_level = cur_level + 2'd1;
      end
    end
    r.level         = cur_level;
    r.level_changed = (cur_level != prev);
    r.target        = tgt_level;
    r.average_mb    = sum[23:4];
    levels_due.push_back(r);
  endfunction

  task report(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task check_result(mplg_pkg::out_item_t got);
    mplg_pkg::out_item_t want;
    if (levels_due.size() == 0) begin
      report($sformatf("result %h with no tick pending", got));
      return;
    end
    want = levels_due.pop_front();
    if (got.level !== want.level)
      report($sformatf("level got %0d want %0d", got.level, want.level));
    if (got.level_changed !== want.level_changed)
      report($sformatf("level_changed got %0d want %0d", got.level_changed,
                       want.level_changed));
    if (got.target !== want.target)
      report($sformatf("target got %0d want %0d", got.target, want.target));
    if (got.average_mb !== want.average_mb)
      report($sformatf("average_mb got %0d want %0d", got.average_mb, want.average_mb));
  endtask

  task report_leftover();
    if (levels_due.size() != 0)
      report($sformatf("%0d results never arrived", levels_due.size()));
  endtask
endclass

module memory_pressure_level_governor_tb;

  localparam int StallLimit = 5000;
  localparam int PhaseTicks = 223;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [2:0]                    cfg_idx_i;
  logic [mplg_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  mplg_pkg::in_item_t            in_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  mplg_pkg::out_item_t           out_data_o;

  governor_scoreboard  sb;
  int                  send_idle_pct = 15;
  int                  recv_idle_pct = 64;
  int                  idle_cycles = 0;

  memory_pressure_level_governor uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // check results before noting the tick of the same edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) sb.check_result(out_data_o);
      if (in_valid_i === 1'b1 && in_ready_o === 1'b1) sb.note_tick(in_data_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic mplg_pkg::in_item_t tick(logic [15:0] d, logic [19:0] mb,
                                              logic [19:0] frac, logic sv);
    mplg_pkg::in_item_t it;
    it.time_delta_ms     = d;
    it.working_set_bytes = {mb, frac};
    it.sample_valid      = sv;
    return it;
  endfunction

  function automatic mplg_pkg::in_item_t random_tick();
    mplg_pkg::in_item_t it;
    int       pick;
    int       base;
    int       v;
    pick = $urandom_range(99);
    if (pick < 5)       it.time_delta_ms = 16'd0;
    else if (pick < 10) it.time_delta_ms = 16'hFFFF;
    else if (pick < 35) it.time_delta_ms = 16'($urandom_range(0, 255));
    else if (pick < 75) it.time_delta_ms = 16'($urandom_range(0, 3000));
    else                it.time_delta_ms = 16'($urandom());
    it.sample_valid = ($urandom_range(99) < 75);
    pick = $urandom_range(99);
    if (pick < 6) begin
      it.working_set_bytes = {8'($urandom()), 32'($urandom())};
    end else begin
      if (pick < 18) begin
        v = $urandom_range(0, 4095);
      end else begin
        // aim at one of the thresholds so the level keeps moving
        case ($urandom_range(2))
          0:       base = int'(sb.thr_mid);
          1:       base = int'(sb.thr_low);
          default: base = int'(sb.thr_vlow);
        endcase
        v = base + int'($urandom_range(0, 400)) - 200;
        if (v < 0) v = 0;
        if (v > 1048575) v = 1048575;
      end
      it.working_set_bytes = {v[19:0], 20'($urandom())};
    end
    return it;
  endfunction

  task automatic send_tick(input mplg_pkg::in_item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // hold the sender until every pending result has been taken
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.levels_due.size() != 0);
  endtask

  task automatic write_reg(input mplg_pkg::cfg_idx_e idx, input logic [19:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [19:0] mid, input logic [19:0] low,
                               input logic [19:0] vlow, input logic [19:0] db,
                               input logic [19:0] d2, input logic [19:0] d3,
                               input logic [19:0] warm, input logic [19:0] lim);
    write_reg(mplg_pkg::CfgThrMid, mid);
    write_reg(mplg_pkg::CfgThrLow, low);
    write_reg(mplg_pkg::CfgThrVeryLow, vlow);
    write_reg(mplg_pkg::CfgDwellBase, db);
    write_reg(mplg_pkg::CfgDwellL2, d2);
    write_reg(mplg_pkg::CfgDwellL3, d3);
    write_reg(mplg_pkg::CfgWarmup, warm);
    write_reg(mplg_pkg::CfgLevelLimit, lim);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int t_mid;
    int t_low;
    int t_vlow;
    sb = new();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= mplg_pkg::CfgThrMid;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // before any sample: average reads zero, level stays at the top
    send_tick(tick(16'd0, 20'd0, 20'd0, 1'b0));
    send_tick(tick(16'hFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0));
    // first sample fills the ring and drops the level at once
    send_tick(tick(16'hFFFF, 20'd1301, 20'd0, 1'b1));
    // warm-up not yet exceeded, then exactly equal: samples dropped
    send_tick(tick(16'd500, 20'd1301, 20'h80000, 1'b1));
    send_tick(tick(16'd1, 20'd1301, 20'd0, 1'b1));
    // recorded now; dwell just past the base time lets the level rise one step
    send_tick(tick(16'd60000, 20'd0, 20'd0, 1'b1));
    // dwell equal to the limit holds, one more millisecond advances
    send_tick(tick(16'd30000, 20'd0, 20'd0, 1'b0));
    send_tick(tick(16'd1, 20'd0, 20'd0, 1'b0));
    send_tick(tick(16'd15001, 20'd0, 20'd0, 1'b1));
    send_tick(tick(16'd0, 20'hFFFFF, 20'hFFFFF, 1'b1));
    send_tick(tick(16'hFFFF, 20'd0, 20'd0, 1'b1));
    send_tick(tick(16'd1234, 20'd1250, 20'hFFFFF, 1'b1));
    send_tick(tick(16'd0, 20'd1150, 20'd1, 1'b1));
    send_tick(tick(16'h8000, 20'd1151, 20'd0, 1'b0));

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      repeat (2) @(posedge clk_i);
      case (ph)
        0: apply_setting(20'd1150, 20'd1250, 20'd1300, 20'd0, 20'd0, 20'd0, 20'd0, 20'd3);
        1: begin
          t_mid  = $urandom_range(2000, 3000);
          t_low  = t_mid + $urandom_range(1, 1000);
          t_vlow = t_low + $urandom_range(1, 1000);
          apply_setting(20'(t_mid), 20'(t_low), 20'(t_vlow), 20'd1000000, 20'd1000000,
                        20'd1000000, 20'd65535, 20'd1);
        end
        2: apply_setting(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'($urandom()), 20'($urandom()),
                         20'($urandom()), 20'($urandom()), 20'd0);
        3: apply_setting(20'($urandom_range(0, 3000)), 20'($urandom_range(0, 3000)),
                         20'($urandom_range(0, 3000)), 20'($urandom_range(0, 100000)),
                         20'($urandom_range(0, 100000)), 20'($urandom_range(0, 100000)),
                         20'($urandom()), 20'($urandom()));
        4: apply_setting(20'd0, 20'd1000, 20'd1400, 20'd5000, 20'd20000, 20'd0, 20'd500,
                         20'd2);
        default: apply_setting(mplg_pkg::ThrMidRst, mplg_pkg::ThrLowRst,
                               mplg_pkg::ThrVeryLowRst, mplg_pkg::DwellBaseRst,
                               mplg_pkg::DwellL2Rst, mplg_pkg::DwellL3Rst,
                               {4'hF, mplg_pkg::WarmupRst},
                               {18'h3FFFF, mplg_pkg::LevelLimitRst});
      endcase
      case (ph / 2)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PhaseTicks; n++) begin
        if (n % 97 == 60) wait_drained();
        send_tick(random_tick());
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
